// File: rtl/dcsp_pkg.sv
// Shared constants and types for the divisor count/sum/product block.
// No dependencies.
package dcsp_pkg;
   localparam int W = 30;
   localparam int EW = 60;
   localparam logic [W-1:0] MOD_C = 30'd1000000007;
   localparam logic [W-1:0] MODM1_C = 30'd1000000006;
   localparam logic [W-1:0] MODM2_C = 30'd1000000005;
   // floor(2^60 / modulus) for the Barrett reduction
   localparam logic [W:0] MU_MOD_C = 31'd1152921496;
   localparam logic [W:0] MU_MODM1_C = 31'd1152921497;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request
      logic start;      // start the current step
      logic [3:0] step; // which step of the sequence
      logic emit;       // copy accumulators to the result, return them to one
   } cmd_type;

   typedef struct packed {
      logic done;
      logic last;
   } status_type;

   localparam logic [3:0] ST_PNUM = 4'd0; // p^(k+1)
   localparam logic [3:0] ST_PINV = 4'd1; // (p-1)^(MOD-2)
   localparam logic [3:0] ST_PPRD = 4'd2; // product^(k+1)
   localparam logic [3:0] ST_PTRI = 4'd3; // p^tri
   localparam logic [3:0] ST_PCNT = 4'd4; // (p^tri)^cexp
   localparam logic [3:0] ST_FCNT = 4'd5; // count * (k+1)
   localparam logic [3:0] ST_FGEO = 4'd6; // num * inv
   localparam logic [3:0] ST_FSUM = 4'd7; // sum * geometric term
   localparam logic [3:0] ST_FPRD = 4'd8; // product fold
   localparam logic [3:0] ST_FCEX = 4'd9; // count exponent mod MOD-1
endpackage

// File: rtl/dcsp_mulmod.sv
// Pipelined modular multiplier: 30x30 product then Barrett reduction; the
// result is registered. Modulus is MOD or MOD-1. Uses dcsp_pkg.
module dcsp_mulmod (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic sel,
   input  logic [dcsp_pkg::W-1:0] a,
   input  logic [dcsp_pkg::W-1:0] b,
   output logic done,
   output logic [dcsp_pkg::W-1:0] y
);
   import dcsp_pkg::*;
   logic [3:0] vld_ff, vld_in;
   logic sel_ff, sel_in;
   logic [2*W-1:0] x_ff, x_in;
   logic [W:0] q3_ff, q3_in;
   logic [31:0] xlo_ff, xlo_in, r_ff, r_in;
   logic [W-1:0] y_ff, y_in;
   logic [W-1:0] modulus;
   logic [W:0] mu;
   logic [2*W+1:0] q2;
   logic [31:0] qm, m1, m2, r_sub;

   always_comb begin
      modulus = sel_ff ? MODM1_C : MOD_C;
      mu = sel_ff ? MU_MODM1_C : MU_MOD_C;
      vld_in = {vld_ff[2:0], start};
      sel_in = start ? sel : sel_ff;
      x_in = start ? (2*W)'(a) * (2*W)'(b) : x_ff;
      // quotient estimate, at most two short of the true one
      q2 = (2*W+2)'(x_ff[2*W-1:W-1]) * (2*W+2)'(mu);
      q3_in = q2[2*W+1:W+1];
      xlo_in = x_ff[31:0];
      // remainder is below three moduli, so 32 bits hold it
      qm = 32'(q3_ff) * 32'(modulus);
      r_in = xlo_ff - qm;
      m1 = 32'(modulus);
      m2 = {m1[30:0], 1'b0};
      if (r_ff >= m2) r_sub = r_ff - m2;
      else if (r_ff >= m1) r_sub = r_ff - m1;
      else r_sub = r_ff;
      y_in = vld_ff[2] ? r_sub[W-1:0] : y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      sel_ff <= sel_in;
      x_ff <= x_in;
      q3_ff <= q3_in;
      xlo_ff <= xlo_in;
      r_ff <= r_in;
      y_ff <= y_in;
   end

   assign done = vld_ff[3];
   assign y = y_ff;
endmodule

// File: rtl/dcsp_ctrl.sv
// Sequencer for the block: handshake and step ordering.
// Uses dcsp_pkg; drives the datapath by a command struct.
module dcsp_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   output logic rsp_valid,
   input  logic rsp_stall,
   input  dcsp_pkg::status_type status,
   output dcsp_pkg::cmd_type cmd
);
   import dcsp_pkg::*;
   localparam logic [1:0] S_IDLE = 2'd0, S_RUN = 2'd1, S_WAIT = 2'd2, S_FIN = 2'd3;
   logic [1:0] state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic out_ff, out_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = out_ff;

   always_comb begin
      state_in = state_ff; step_in = step_ff; out_in = out_ff;
      cmd = '0; cmd.step = step_ff;
      if (out_ff && !rsp_stall) out_in = 1'b0;
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.load = 1'b1; step_in = ST_PNUM; state_in = S_RUN;
         end
         S_RUN: begin
            cmd.start = 1'b1; state_in = S_WAIT;
         end
         S_WAIT: if (status.done) begin
            if (step_ff == ST_FCEX) begin
               state_in = S_FIN;
            end else begin
               step_in = step_ff + 4'd1; state_in = S_RUN;
            end
         end
         S_FIN: begin
            // last factor: hold until the result slot is free; else return to idle
            if (!status.last) begin
               state_in = S_IDLE;
            end else if (!out_ff || !rsp_stall) begin
               cmd.emit = 1'b1; out_in = 1'b1; state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; step_ff <= ST_PNUM; out_ff <= 1'b0;
      end else begin
         state_ff <= state_in; step_ff <= step_in; out_ff <= out_in;
      end
   end
endmodule

// File: rtl/dcsp_dp.sv
// Datapath: accumulators, square-and-multiply exponentiator, step results.
// Uses dcsp_pkg and dcsp_mulmod.
module dcsp_dp (
   input  logic clock,
   input  logic reset,
   input  dcsp_pkg::cmd_type cmd,
   output dcsp_pkg::status_type status,
   input  logic [dcsp_pkg::W-1:0] req_prime,
   input  logic [dcsp_pkg::W-1:0] req_exponent,
   input  logic req_last_factor,
   output logic [dcsp_pkg::W-1:0] rsp_divisor_count,
   output logic [dcsp_pkg::W-1:0] rsp_divisor_sum,
   output logic [dcsp_pkg::W-1:0] rsp_divisor_product
);
   import dcsp_pkg::*;
   localparam logic [2:0] E_IDLE = 3'd0, E_MUL = 3'd1, E_SQ = 3'd2, E_ONE = 3'd3,
      E_DONE = 3'd4;
   logic [W-1:0] p_ff, k1m_ff, k1e_ff, cnt_ff, sum_ff, prd_ff, cexp_ff;
   logic [W:0] k1_ff;
   logic [W-1:0] num_ff, inv_ff, pprd_ff, ptri_ff, pcnt_ff, geo_ff;
   logic [EW-1:0] tri_ff;
   logic last_ff, pone_ff;
   logic [W-1:0] res_cnt_ff, res_sum_ff, res_prd_ff;
   // exponentiator
   logic [2:0] es_ff, es_in;
   logic [W-1:0] base_ff, base_in, acc_ff, acc_in, ma_ff, ma_in, mb_ff, mb_in;
   logic [EW-1:0] e_ff, e_in;
   logic go_ff, go_in, msel_ff, msel_in;
   logic m_done;
   logic [W-1:0] m_y;
   logic [W-1:0] pow_base, fold_a, fold_b, pm1;
   logic [EW-1:0] pow_exp, e_next;
   logic [W:0] p_red, k1_w, k1m_w, k1e_w;
   logic [2*W:0] tri_w;
   logic fold_wr;

   dcsp_mulmod u_mul (.clock, .reset, .start(go_ff), .sel(msel_ff), .a(ma_ff), .b(mb_ff),
      .done(m_done), .y(m_y));

   assign p_red = ({1'b0, req_prime} >= {1'b0, MOD_C}) ?
      {1'b0, req_prime} - {1'b0, MOD_C} : {1'b0, req_prime};
   assign k1_w = {1'b0, req_exponent} + (W+1)'(1);
   assign k1m_w = (k1_w >= {1'b0, MOD_C}) ? k1_w - {1'b0, MOD_C} : k1_w;
   assign k1e_w = (k1_w >= {1'b0, MODM1_C}) ? k1_w - {1'b0, MODM1_C} : k1_w;
   assign tri_w = (2*W+1)'(req_exponent) * (2*W+1)'(k1_w);
   assign pm1 = (p_ff == '0) ? MODM1_C : p_ff - W'(1);
   assign e_next = e_ff >> 1;
   assign fold_wr = (es_ff == E_ONE) && m_done;

   always_comb begin
      pow_base = p_ff; pow_exp = EW'(k1_ff);
      case (cmd.step)
         ST_PNUM: begin pow_base = p_ff; pow_exp = EW'(k1_ff); end
         ST_PINV: begin pow_base = pm1; pow_exp = EW'(MODM2_C); end
         ST_PPRD: begin pow_base = prd_ff; pow_exp = EW'(k1_ff); end
         ST_PTRI: begin pow_base = p_ff; pow_exp = tri_ff; end
         ST_PCNT: begin pow_base = ptri_ff; pow_exp = EW'(cexp_ff); end
         default: ;
      endcase
      fold_a = cnt_ff; fold_b = k1m_ff;
      case (cmd.step)
         ST_FGEO: begin fold_a = num_ff; fold_b = inv_ff; end
         // p = 1 mod MOD: the geometric sum is k+1
         ST_FSUM: begin fold_a = sum_ff; fold_b = pone_ff ? k1m_ff : geo_ff; end
         ST_FPRD: begin fold_a = pprd_ff; fold_b = pcnt_ff; end
         ST_FCEX: begin fold_a = cexp_ff; fold_b = k1e_ff; end
         default: ;
      endcase
   end

   // exponentiator sequencing
   always_comb begin
      es_in = es_ff; go_in = 1'b0; ma_in = ma_ff; mb_in = mb_ff; msel_in = msel_ff;
      base_in = base_ff; acc_in = acc_ff; e_in = e_ff;
      unique case (es_ff)
         E_IDLE: if (cmd.start) begin
            if (cmd.step <= ST_PCNT) begin
               base_in = pow_base; e_in = pow_exp; acc_in = W'(1); msel_in = 1'b0;
               if (pow_exp == '0) begin
                  es_in = E_DONE;
               end else if (pow_exp[0]) begin
                  ma_in = W'(1); mb_in = pow_base; go_in = 1'b1; es_in = E_MUL;
               end else begin
                  ma_in = pow_base; mb_in = pow_base; go_in = 1'b1; es_in = E_SQ;
               end
            end else begin
               ma_in = fold_a; mb_in = fold_b; msel_in = (cmd.step == ST_FCEX);
               go_in = 1'b1; es_in = E_ONE;
            end
         end
         E_MUL: if (m_done) begin
            acc_in = m_y;
            if (e_next == '0) begin
               es_in = E_DONE;
            end else begin
               ma_in = base_ff; mb_in = base_ff; go_in = 1'b1; es_in = E_SQ;
            end
         end
         E_SQ: if (m_done) begin
            base_in = m_y; e_in = e_next;
            if (e_next[0]) begin
               ma_in = acc_ff; mb_in = m_y; go_in = 1'b1; es_in = E_MUL;
            end else begin
               ma_in = m_y; mb_in = m_y; go_in = 1'b1; es_in = E_SQ;
            end
         end
         E_ONE: if (m_done) es_in = E_DONE;
         E_DONE: es_in = E_IDLE;
         default: es_in = E_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         es_ff <= E_IDLE; go_ff <= 1'b0;
      end else begin
         es_ff <= es_in; go_ff <= go_in;
      end
      ma_ff <= ma_in; mb_ff <= mb_in; msel_ff <= msel_in;
      base_ff <= base_in; acc_ff <= acc_in; e_ff <= e_in;
   end

   assign status.done = (es_ff == E_DONE);
   assign status.last = last_ff;
   assign rsp_divisor_count = res_cnt_ff;
   assign rsp_divisor_sum = res_sum_ff;
   assign rsp_divisor_product = res_prd_ff;

   // accumulators and result
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= W'(1); sum_ff <= W'(1); prd_ff <= W'(1); cexp_ff <= W'(1);
         res_cnt_ff <= '0; res_sum_ff <= '0; res_prd_ff <= '0;
      end else if (cmd.emit) begin
         res_cnt_ff <= cnt_ff; res_sum_ff <= sum_ff; res_prd_ff <= prd_ff;
         cnt_ff <= W'(1); sum_ff <= W'(1); prd_ff <= W'(1); cexp_ff <= W'(1);
      end else if (fold_wr) begin
         case (cmd.step)
            ST_FCNT: cnt_ff <= m_y;
            ST_FSUM: sum_ff <= m_y;
            ST_FPRD: prd_ff <= m_y;
            ST_FCEX: cexp_ff <= m_y;
            default: ;
         endcase
      end
   end

   // capture the request and the step results
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         p_ff <= p_red[W-1:0];
         k1_ff <= k1_w;
         k1m_ff <= k1m_w[W-1:0];
         k1e_ff <= k1e_w[W-1:0];
         tri_ff <= tri_w[2*W:1];
         last_ff <= req_last_factor;
         pone_ff <= (p_red[W-1:0] == W'(1));
      end
      if (es_ff == E_DONE) begin
         case (cmd.step)
            ST_PNUM: num_ff <= (acc_ff == '0) ? MODM1_C : acc_ff - W'(1);
            ST_PINV: inv_ff <= acc_ff;
            ST_PPRD: pprd_ff <= acc_ff;
            ST_PTRI: ptri_ff <= acc_ff;
            ST_PCNT: pcnt_ff <= acc_ff;
            default: ;
         endcase
      end
      if (fold_wr && cmd.step == ST_FGEO) geo_ff <= m_y;
   end
endmodule

// File: rtl/divisor_count_sum_product_mod.sv
// Divisor count, sum and product of a number modulo 1000000007, fed as its
// prime factorisation one (prime, exponent) request at a time. Every modular
// multiply goes through one shared pipelined multiplier; a request runs five
// square-and-multiply exponentiations and five folds, and the exponentiation
// with the 59-bit triangular exponent takes the longest. Requests are taken
// one at a time; a waiting result does not block the next request until that
// one is ready to post its own result.
// Depends on dcsp_pkg, dcsp_ctrl, dcsp_dp.
module divisor_count_sum_product_mod (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [dcsp_pkg::W-1:0] req_prime,
   input  logic [dcsp_pkg::W-1:0] req_exponent,
   input  logic req_last_factor,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [dcsp_pkg::W-1:0] rsp_divisor_count,
   output logic [dcsp_pkg::W-1:0] rsp_divisor_sum,
   output logic [dcsp_pkg::W-1:0] rsp_divisor_product
);
   import dcsp_pkg::*;
   cmd_type cmd;
   status_type status;

   dcsp_ctrl u_ctrl (.clock, .reset, .req_valid, .req_stall, .rsp_valid,
      .rsp_stall, .status, .cmd);
   dcsp_dp u_dp (.clock, .reset, .cmd, .status, .req_prime, .req_exponent,
      .req_last_factor, .rsp_divisor_count, .rsp_divisor_sum,
      .rsp_divisor_product);
endmodule
